/* sv/sha1_pkg.sv */
// sha1_pkg: shared types, constants and a helper function for the sha-1 stream hasher
// depends on nothing; imported by sha1_ctrl, sha1_dpath and sha1_stream_hasher
package sha1_pkg;

	localparam int WORD_W     = 32;
	localparam int NUM_WORDS  = 5;
	localparam int BLK_WORDS  = 16;
	localparam int ROUNDS     = 80;

	localparam logic [6:0] ROUND_LAST = 7'(ROUNDS - 1);
	localparam logic [5:0] FILL_LAST  = 6'd63;
	localparam logic [5:0] FILL_PAD   = 6'd56;
	localparam logic [2:0] OUT_COUNT  = 3'(NUM_WORDS);

	localparam logic [31:0] K_R0 = 32'h5A827999;
	localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
	localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
	localparam logic [31:0] K_R3 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	typedef logic [1:0] byte_src_t;
	localparam byte_src_t SRC_DATA = 2'd0;
	localparam byte_src_t SRC_PAD  = 2'd1;
	localparam byte_src_t SRC_ZERO = 2'd2;
	localparam byte_src_t SRC_LEN  = 2'd3;

	typedef struct packed {
		logic      push;
		byte_src_t src;
		logic      count_msg;
		logic      latch_len;
		logic      round;
		logic      add;
		logic      add_final;
	} sha1_cmd_t;

	typedef struct packed {
		logic fill_last;
		logic fill_pad_end;
		logic round_last;
		logic out_busy;
	} sha1_sts_t;

	function automatic logic [31:0] init_word(input logic [2:0] idx);
		logic [31:0] w;
		case (idx)
			3'd0: w = 32'h67452301;
			3'd1: w = 32'hEFCDAB89;
			3'd2: w = 32'h98BADCFE;
			3'd3: w = 32'h10325476;
			3'd4: w = 32'hC3D2E1F0;
			default: w = 32'h0;
		endcase
		return w;
	endfunction

endpackage

/* sv/sha1_ctrl.sv */
// sha1_ctrl: state machine that sequences absorb, padding, rounds and digest load
// depends on sha1_pkg; drives sha1_dpath through command and status structs
module sha1_ctrl
	import sha1_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      operation,
	output logic      in_stall,
	input  sha1_sts_t sts,
	output sha1_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PADZ  = 3'd1;
	localparam logic [2:0] ST_PADL  = 3'd2;
	localparam logic [2:0] ST_ROUND = 3'd3;
	localparam logic [2:0] ST_ADD   = 3'd4;

	logic [2:0] state_q, state_d;
	logic       fin_q, fin_d;
	logic       lenph_q, lenph_d;
	logic       accept;

	always_comb begin
		state_d  = state_q;
		fin_d    = fin_q;
		lenph_d  = lenph_q;
		in_stall = 1'b1;
		accept   = 1'b0;
		cmd      = '0;
		cmd.src  = SRC_DATA;
		case (state_q)
			ST_IDLE: begin
				in_stall = operation & sts.out_busy;
				accept   = in_valid & ~in_stall;
				if (accept) begin
					cmd.push = 1'b1;
					if (operation) begin
						cmd.src       = SRC_PAD;
						cmd.latch_len = 1'b1;
						fin_d         = 1'b1;
						state_d       = sts.fill_last ? ST_ROUND : ST_PADZ;
					end else begin
						cmd.src       = SRC_DATA;
						cmd.count_msg = 1'b1;
						if (sts.fill_last) begin
							state_d = ST_ROUND;
						end
					end
				end
			end
			ST_PADZ: begin
				if (sts.fill_pad_end) begin
					lenph_d = 1'b1;
					state_d = ST_PADL;
				end else begin
					cmd.push = 1'b1;
					cmd.src  = SRC_ZERO;
					if (sts.fill_last) begin
						state_d = ST_ROUND;
					end
				end
			end
			ST_PADL: begin
				cmd.push = 1'b1;
				cmd.src  = SRC_LEN;
				if (sts.fill_last) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				if (sts.round_last) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				cmd.add       = 1'b1;
				cmd.add_final = fin_q & lenph_q;
				if (!fin_q) begin
					state_d = ST_IDLE;
				end else if (lenph_q) begin
					fin_d   = 1'b0;
					lenph_d = 1'b0;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_PADZ;
				end
			end
			default: begin
				state_d = ST_IDLE;
				fin_d   = 1'b0;
				lenph_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fin_q   <= 1'b0;
			lenph_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fin_q   <= fin_d;
			lenph_q <= lenph_d;
		end
	end

	// round loop always hands over to the chaining add
	a_round_to_add: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && sts.round_last) |=> (state_q == ST_ADD))
		else $error("round loop did not end in add");

	// length bytes only go out while a finish is in progress
	a_len_in_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PADL) |-> fin_q)
		else $error("length padding outside finish");

	// a full block always starts the rounds
	a_full_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push && sts.fill_last) |=> (state_q == ST_ROUND))
		else $error("full block did not start compression");

endmodule

/* sv/sha1_dpath.sv */
// sha1_dpath: block window, message schedule, round unit, chaining words and digest queue
// depends on sha1_pkg; commanded by sha1_ctrl
module sha1_dpath
	import sha1_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  sha1_cmd_t   cmd,
	input  logic [7:0]  data_byte,
	input  logic        out_stall,
	output sha1_sts_t   sts,
	output logic        out_valid,
	output logic [31:0] digest_word,
	output logic        last_word
);

	logic [5:0]  fill_q;
	logic [63:0] msg_q;
	logic [63:0] len_q;
	logic [23:0] asm_q;
	logic [31:0] win_q [BLK_WORDS];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [31:0] h_q [NUM_WORDS];
	logic [31:0] dig_q [NUM_WORDS];
	logic [6:0]  round_q;
	logic [2:0]  ocnt_q;

	logic [7:0]  byte_in;
	logic [31:0] sched_w;
	logic [31:0] sched_x;
	logic [31:0] f_val;
	logic [31:0] k_val;
	logic [31:0] t_val;
	logic [31:0] sum [NUM_WORDS];
	logic        word_done;
	logic        blk_full;
	logic        out_take;

	always_comb begin
		case (cmd.src)
			SRC_DATA: byte_in = data_byte;
			SRC_PAD:  byte_in = PAD_BYTE;
			SRC_ZERO: byte_in = 8'h00;
			SRC_LEN:  byte_in = len_q[63:56];
			default:  byte_in = 8'h00;
		endcase
	end

	assign word_done = cmd.push & (fill_q[1:0] == 2'b11);
	assign blk_full  = cmd.push & (fill_q == FILL_LAST);
	assign out_take  = out_valid & ~out_stall;

	assign sched_x = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
	assign sched_w = {sched_x[30:0], sched_x[31]};

	always_comb begin
		if (round_q < 7'd20) begin
			f_val = (b_q & c_q) | (~b_q & d_q);
			k_val = K_R0;
		end else if (round_q < 7'd40) begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = K_R1;
		end else if (round_q < 7'd60) begin
			f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k_val = K_R2;
		end else begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = K_R3;
		end
	end

	assign t_val = {a_q[26:0], a_q[31:27]} + f_val + e_q + win_q[0] + k_val;

	assign sum[0] = h_q[0] + a_q;
	assign sum[1] = h_q[1] + b_q;
	assign sum[2] = h_q[2] + c_q;
	assign sum[3] = h_q[3] + d_q;
	assign sum[4] = h_q[4] + e_q;

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			msg_q   <= '0;
			round_q <= '0;
			ocnt_q  <= '0;
			for (int i = 0; i < NUM_WORDS; i++) begin
				h_q[i] <= init_word(3'(i));
			end
		end else begin
			if (cmd.push) begin
				fill_q <= fill_q + 6'd1;
			end
			if (cmd.latch_len) begin
				msg_q <= '0;
			end else if (cmd.count_msg) begin
				msg_q <= msg_q + 64'd1;
			end
			if (blk_full) begin
				round_q <= '0;
			end else if (cmd.round) begin
				round_q <= round_q + 7'd1;
			end
			if (cmd.add) begin
				for (int i = 0; i < NUM_WORDS; i++) begin
					h_q[i] <= cmd.add_final ? init_word(3'(i)) : sum[i];
				end
			end
			if (cmd.add_final) begin
				ocnt_q <= OUT_COUNT;
			end else if (out_take) begin
				ocnt_q <= ocnt_q - 3'd1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			asm_q <= {asm_q[15:0], byte_in};
		end
		if (cmd.latch_len) begin
			len_q <= {msg_q[60:0], 3'b000};
		end else if (cmd.push && cmd.src == SRC_LEN) begin
			len_q <= {len_q[55:0], 8'h00};
		end
		if (word_done || cmd.round) begin
			for (int i = 0; i < BLK_WORDS - 1; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[BLK_WORDS - 1] <= word_done ? {asm_q, byte_in} : sched_w;
		end
		if (blk_full) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (cmd.round) begin
			a_q <= t_val;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
		if (cmd.add_final) begin
			for (int i = 0; i < NUM_WORDS; i++) begin
				dig_q[i] <= sum[i];
			end
		end else if (out_take) begin
			for (int i = 0; i < NUM_WORDS - 1; i++) begin
				dig_q[i] <= dig_q[i + 1];
			end
		end
	end

	assign out_valid   = (ocnt_q != 3'd0);
	assign digest_word = dig_q[0];
	assign last_word   = (ocnt_q == 3'd1);

	assign sts.fill_last    = (fill_q == FILL_LAST);
	assign sts.fill_pad_end = (fill_q == FILL_PAD);
	assign sts.round_last   = (round_q == ROUND_LAST);
	assign sts.out_busy     = out_valid;

	// a new digest never overwrites words still queued
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.add_final |-> !sts.out_busy)
		else $error("digest loaded while previous digest pending");

	// queue count stays within the digest length
	a_ocnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q <= OUT_COUNT)
		else $error("digest word count out of range");

	// bytes are never pushed in the middle of the round loop
	a_no_push_in_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.round |-> !cmd.push)
		else $error("byte pushed during compression");

endmodule

/* sv/sha1_stream_hasher.sv */
// sha1_stream_hasher: byte-wide sha-1 hasher; the 64th byte of a block starts the 80 rounds,
// one per cycle, then the chaining add, and the input stalls until the add is done
// finish pads with the 0x80 byte, zero bytes and the bit length and runs one or two
// compressions; the digest then comes out as five words as the output side takes them
// absorb words are accepted while digest words drain; a new finish waits for the queue
// arst_n restores the initial chaining words and clears byte and length counts
module sha1_stream_hasher
	import sha1_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic        last_word
);

	sha1_cmd_t cmd;
	sha1_sts_t sts;

	sha1_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.operation (operation),
		.in_stall  (in_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	sha1_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.data_byte   (data_byte),
		.out_stall   (out_stall),
		.sts         (sts),
		.out_valid   (out_valid),
		.digest_word (digest_word),
		.last_word   (last_word)
	);

endmodule

/* tb/tb_top.sv */
// tb_top: self-checking testbench for sha1_stream_hasher, byte messages in, digest words out
// holds its own sha-1 predictor and compares every digest word; depends on sha1_pkg and the rtl
`timescale 1ns / 1ps

module tb_top;
	import sha1_pkg::*;

	typedef enum logic {OP_ABSORB = 1'b0, OP_FINISH = 1'b1} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
	} in_word_t;

	typedef struct packed {
		logic [31:0] word;
		logic        last;
	} digest_word_t;

	localparam int QUIET_LIMIT  = 5000;
	localparam int PHASE_WORDS  = 55;
	localparam int NUM_PHASES   = 4;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic        operation = OP_ABSORB;
	logic [7:0]  data_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] digest_word;
	logic        last_word;

	in_word_t     pending_words[$];
	digest_word_t expected_digest[$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int quiet_cycles   = 0;
	int fail_count     = 0;
	int words_in       = 0;
	int messages_done  = 0;
	int digest_checked = 0;

	// predictor state
	logic [31:0] hash_state[5];
	logic [7:0]  block_bytes[64];
	logic [6:0]  fill_level;
	logic [63:0] byte_total;

	sha1_stream_hasher dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.operation   (operation),
		.data_byte   (data_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.digest_word (digest_word),
		.last_word   (last_word)
	);

	function automatic void hash_restart();
		hash_state[0] = 32'h67452301;
		hash_state[1] = 32'hEFCDAB89;
		hash_state[2] = 32'h98BADCFE;
		hash_state[3] = 32'h10325476;
		hash_state[4] = 32'hC3D2E1F0;
		fill_level = '0;
		byte_total = '0;
	endfunction

	function automatic void compress_block();
		logic [31:0] w[80];
		logic [31:0] a, b, c, d, e, f, k, t, x;
		for (int i = 0; i < 16; i++)
			w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
		for (int i = 16; i < 80; i++) begin
			x = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
			w[i] = {x[30:0], x[31]};
		end
		a = hash_state[0];
		b = hash_state[1];
		c = hash_state[2];
		d = hash_state[3];
		e = hash_state[4];
		for (int i = 0; i < 80; i++) begin
			if (i < 20) begin
				f = (b & c) | (~b & d);
				k = K_R0;
			end else if (i < 40) begin
				f = b ^ c ^ d;
				k = K_R1;
			end else if (i < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = K_R2;
			end else begin
				f = b ^ c ^ d;
				k = K_R3;
			end
			t = {a[26:0], a[31:27]} + f + e + w[i] + k;
			e = d;
			d = c;
			c = {b[1:0], b[31:2]};
			b = a;
			a = t;
		end
		hash_state[0] += a;
		hash_state[1] += b;
		hash_state[2] += c;
		hash_state[3] += d;
		hash_state[4] += e;
	endfunction

	function automatic void hash_word_in(op_t op, logic [7:0] data);
		int pos;
		logic [63:0] bit_len;
		if (op == OP_ABSORB) begin
			block_bytes[fill_level[5:0]] = data;
			fill_level = fill_level + 7'd1;
			byte_total = byte_total + 64'd1;
			if (fill_level >= 7'd64) begin
				compress_block();
				fill_level = '0;
			end
		end else begin
			pos = fill_level[5:0];
			block_bytes[pos] = PAD_BYTE;
			pos++;
			if (pos > 56) begin
				while (pos < 64) begin
					block_bytes[pos] = 8'h00;
					pos++;
				end
				compress_block();
				pos = 0;
			end
			while (pos < 56) begin
				block_bytes[pos] = 8'h00;
				pos++;
			end
			bit_len = byte_total << 3;
			for (int i = 0; i < 8; i++)
				block_bytes[56+i] = bit_len[63-8*i -: 8];
			compress_block();
			for (int i = 0; i < 5; i++)
				expected_digest.push_back('{word: hash_state[i], last: (i == 4)});
			hash_restart();
			messages_done++;
		end
	endfunction

	function automatic void queue_message(int len);
		for (int i = 0; i < len; i++)
			pending_words.push_back('{op: OP_ABSORB, data: 8'($urandom_range(255))});
		pending_words.push_back('{op: OP_FINISH, data: 8'($urandom_range(255))});
	endfunction

	function automatic int pick_length();
		int edge_len[6] = '{55, 56, 57, 63, 64, 65};
		int r;
		r = $urandom_range(9);
		if (r == 0)
			return 0;
		else if (r <= 3)
			return $urandom_range(1, 12);
		else if (r <= 6)
			return edge_len[$urandom_range(5)];
		return $urandom_range(0, 70);
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin : drive
		in_word_t nxt;
		if (!arst_n) begin
			in_valid  <= 1'b0;
			operation <= OP_ABSORB;
			data_byte <= 8'h00;
			hash_restart();
		end else begin
			if (in_valid && !in_stall) begin
				hash_word_in(op_t'(operation), data_byte);
				words_in++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = pending_words.pop_front();
					in_valid  <= 1'b1;
					operation <= nxt.op;
					data_byte <= nxt.data;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin : watch
		digest_word_t exp_w;
		if (!arst_n) begin
			out_stall    <= 1'b0;
			quiet_cycles <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_digest.size() == 0) begin
					$error("unexpected digest word %h last %b", digest_word, last_word);
					fail_count++;
				end else begin
					exp_w = expected_digest.pop_front();
					digest_checked++;
					if (digest_word !== exp_w.word) begin
						$error("digest_word: expected %h, got %h", exp_w.word, digest_word);
						fail_count++;
					end
					if (last_word !== exp_w.last) begin
						$error("last_word: expected %b, got %b", exp_w.last, last_word);
						fail_count++;
					end
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$error("timeout: no word moved for %0d cycles", QUIET_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : stimulus
		int send_pct[NUM_PHASES]  = '{0, 65, 0, 32};
		int stall_pct[NUM_PHASES] = '{0, 0, 65, 32};
		int target;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty message, with a nonzero byte on the finish word
		pending_words.push_back('{op: OP_FINISH, data: 8'hA5});
		// "abc"
		pending_words.push_back('{op: OP_ABSORB, data: 8'h61});
		pending_words.push_back('{op: OP_ABSORB, data: 8'h62});
		pending_words.push_back('{op: OP_ABSORB, data: 8'h63});
		pending_words.push_back('{op: OP_FINISH, data: 8'h00});
		// byte extremes
		pending_words.push_back('{op: OP_ABSORB, data: 8'h00});
		pending_words.push_back('{op: OP_ABSORB, data: 8'hFF});
		pending_words.push_back('{op: OP_FINISH, data: 8'hFF});
		// back-to-back finish
		pending_words.push_back('{op: OP_FINISH, data: 8'h00});

		for (int p = 0; p < NUM_PHASES; p++) begin
			send_idle_pct  = send_pct[p];
			recv_stall_pct = stall_pct[p];
			target = pending_words.size() + PHASE_WORDS;
			while (pending_words.size() < target)
				queue_message(pick_length());
			// hold off new words until the whole phase has drained
			while (pending_words.size() != 0 || in_valid || expected_digest.size() != 0)
				@(posedge clk);
			@(negedge clk);
		end

		repeat (300) @(posedge clk);
		$display("%0d words sent, %0d messages hashed, %0d digest words checked",
			words_in, messages_done, digest_checked);
		$display("phases: no idling, sender idle, receiver stalling, both; lengths near block edges");
		if (fail_count == 0 && expected_digest.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

/* filelist.f */
sv/sha1_pkg.sv
sv/sha1_ctrl.sv
sv/sha1_dpath.sv
sv/sha1_stream_hasher.sv
tb/tb_top.sv
